@@ design/gcd_pkg.sv @@
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types, constants and reset tables for the greedy cash dispense unit.
// ----------------------------------------------------------------------------
package gcd_pkg;

	localparam int VAL_W     = 16;  // bill value and amount width
	localparam int CNT_W     = 7;   // bill count width
	localparam int BIT_W     = 3;   // quotient bit index width
	localparam int CFG_IDX_W = 3;   // configuration register index width
	localparam int NUM_REGS  = 5;   // denomination registers
	localparam int SHIFT_W   = VAL_W + CNT_W;

	localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(CNT_W - 1);

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_CHECK = 5'b00100,
		ST_EMIT  = 5'b01000,
		ST_RESP  = 5'b10000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture amount, restart the slot walk
		logic div;      // one quotient bit of the current slot
		logic rewind;   // back to slot 0 for the commit walk
		logic emit;     // commit and report the current slot
		logic resp;     // single ok or failed result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic amount_zero;
		logic slot_done;
		logic slot_last;
		logic rem_zero;
		logic emit_adv;
		logic out_free;
	} sts_t;

	function automatic logic [VAL_W-1:0] reset_denom(input int s);
		logic [VAL_W-1:0] v;
		begin
			unique case (s)
				0: v = VAL_W'(50);
				1: v = VAL_W'(20);
				2: v = VAL_W'(10);
				3: v = VAL_W'(5);
				4: v = VAL_W'(2);
				default: v = '0;
			endcase
			return v;
		end
	endfunction

	function automatic logic [CNT_W-1:0] reset_count(input int s, input int max_count);
		int c;
		begin
			unique case (s)
				0: c = 2;
				1: c = 2;
				2: c = 4;
				3: c = 2;
				4: c = 8;
				default: c = 0;
			endcase
			if (c > max_count) begin
				c = max_count;
			end
			return CNT_W'(c);
		end
	endfunction

endpackage

@@ design/gcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// gcd_ctrl
// Sequencer: slot walk with bit-serial quotient, check, commit walk, reply.
// ----------------------------------------------------------------------------
module gcd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  gcd_pkg::sts_t sts,
	output gcd_pkg::cmd_t cmd
);

	gcd_pkg::state_t state_q;
	gcd_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			gcd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.amount_zero ? gcd_pkg::ST_RESP : gcd_pkg::ST_DIV;
				end
			end
			gcd_pkg::ST_DIV: begin
				cmd.div = 1'b1;
				if (sts.slot_done && sts.slot_last) begin
					state_d = gcd_pkg::ST_CHECK;
				end
			end
			gcd_pkg::ST_CHECK: begin
				cmd.rewind = 1'b1;
				state_d    = sts.rem_zero ? gcd_pkg::ST_EMIT : gcd_pkg::ST_RESP;
			end
			gcd_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.emit_adv && sts.slot_last) begin
					state_d = gcd_pkg::ST_IDLE;
				end
			end
			gcd_pkg::ST_RESP: begin
				cmd.resp = 1'b1;
				if (sts.out_free) begin
					state_d = gcd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gcd_pkg::ST_IDLE;
			end
		endcase
	end

	// a new request is only taken with the sequencer idle
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == gcd_pkg::ST_IDLE)
		else $error("in_ready outside idle");

	// the walk never skips the check before committing
	a_emit_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gcd_pkg::ST_EMIT && $past(state_q) != gcd_pkg::ST_EMIT)
		|-> $past(state_q) == gcd_pkg::ST_CHECK)
		else $error("commit walk entered without check");

	// the failure check only follows a finished walk
	a_check_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gcd_pkg::ST_CHECK |-> $past(state_q) == gcd_pkg::ST_DIV)
		else $error("check entered outside the slot walk");

endmodule

@@ design/gcd_dp.sv @@
// ----------------------------------------------------------------------------
// gcd_dp
// Datapath: denominations, bill counts, bit-serial bounded quotient,
// per-slot take registers and the result register.
// ----------------------------------------------------------------------------
module gcd_dp #(
	parameter int SLOTS     = 5,
	parameter int MAX_COUNT = 100
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gcd_pkg::cmd_t                   cmd,
	output gcd_pkg::sts_t                   sts,
	input  logic [gcd_pkg::VAL_W-1:0]       amount,
	input  logic                            cfg_we,
	input  logic [gcd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gcd_pkg::VAL_W-1:0]       cfg_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            status,
	output logic [gcd_pkg::VAL_W-1:0]       bill_value,
	output logic [gcd_pkg::CNT_W-1:0]       bill_count,
	output logic                            last
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

	logic [gcd_pkg::VAL_W-1:0] denom_q [SLOTS];
	logic [gcd_pkg::CNT_W-1:0] count_q [SLOTS];
	logic [gcd_pkg::CNT_W-1:0] take_q  [SLOTS];
	logic [gcd_pkg::VAL_W-1:0] rem_q;
	logic [gcd_pkg::CNT_W-1:0] quo_q;
	logic [gcd_pkg::BIT_W-1:0] bit_q;
	logic [SLOT_W-1:0]         idx_q;

	logic                            out_valid_q;
	logic                            status_q;
	logic [gcd_pkg::VAL_W-1:0]       value_q;
	logic [gcd_pkg::CNT_W-1:0]       cnt_out_q;
	logic                            last_q;

	logic [gcd_pkg::VAL_W-1:0]   cur_val;
	logic [gcd_pkg::CNT_W-1:0]   cur_cnt;
	logic [gcd_pkg::CNT_W-1:0]   cur_take;
	logic [gcd_pkg::CNT_W-1:0]   cand;
	logic [gcd_pkg::SHIFT_W-1:0] shifted;
	logic                        fits;
	logic                        skip;
	logic [gcd_pkg::CNT_W-1:0]   quo_next;
	logic [gcd_pkg::VAL_W-1:0]   rem_next;
	logic                        later_nz;
	logic                        out_free;
	logic                        emit_load;
	logic                        resp_load;

	assign cur_val  = denom_q[idx_q];
	assign cur_cnt  = count_q[idx_q];
	assign cur_take = take_q[idx_q];

	// try setting one more quotient bit: stays within supply and within remainder
	assign cand     = quo_q | (gcd_pkg::CNT_W'(1) << bit_q);
	assign shifted  = gcd_pkg::SHIFT_W'(cur_val) << bit_q;
	assign fits     = (cand <= cur_cnt) && (gcd_pkg::SHIFT_W'(rem_q) >= shifted);
	assign quo_next = fits ? cand : quo_q;
	assign rem_next = fits ? (rem_q - shifted[gcd_pkg::VAL_W-1:0]) : rem_q;
	assign skip     = (cur_val == '0) || (rem_q == '0) || (cur_cnt == '0);

	always_comb begin
		later_nz = 1'b0;
		for (int t = 0; t < SLOTS; t++) begin
			if (SLOT_W'(t) > idx_q && take_q[t] != '0) begin
				later_nz = 1'b1;
			end
		end
	end

	assign out_free  = !out_valid_q || out_ready;
	assign emit_load = cmd.emit && (cur_take != '0) && out_free;
	assign resp_load = cmd.resp && out_free;

	assign sts.amount_zero = (amount == '0);
	assign sts.slot_done   = skip || (bit_q == '0);
	assign sts.slot_last   = (idx_q == LAST_SLOT);
	assign sts.rem_zero    = (rem_q == '0);
	assign sts.emit_adv    = (cur_take == '0) || out_free;
	assign sts.out_free    = out_free;

	// denominations and bill supply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				denom_q[s] <= gcd_pkg::reset_denom(s);
				count_q[s] <= gcd_pkg::reset_count(s, MAX_COUNT);
			end
		end else begin
			for (int s = 0; s < SLOTS; s++) begin
				if (cfg_we && s < gcd_pkg::NUM_REGS
						&& cfg_index == gcd_pkg::CFG_IDX_W'(s)) begin
					denom_q[s] <= cfg_data;
				end
			end
			if (emit_load) begin
				count_q[idx_q] <= cur_cnt - cur_take;
			end
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= amount;
			quo_q <= '0;
			bit_q <= gcd_pkg::TOP_BIT;
			idx_q <= '0;
			for (int s = 0; s < SLOTS; s++) begin
				take_q[s] <= '0;
			end
		end else if (cmd.div) begin
			if (skip) begin
				// remainder may run out mid-slot, keep the bits found so far
				take_q[idx_q] <= quo_q;
				quo_q         <= '0;
				bit_q         <= gcd_pkg::TOP_BIT;
				if (idx_q != LAST_SLOT) begin
					idx_q <= idx_q + SLOT_W'(1);
				end
			end else begin
				rem_q <= rem_next;
				if (bit_q == '0) begin
					take_q[idx_q] <= quo_next;
					quo_q         <= '0;
					bit_q         <= gcd_pkg::TOP_BIT;
					if (idx_q != LAST_SLOT) begin
						idx_q <= idx_q + SLOT_W'(1);
					end
				end else begin
					quo_q <= quo_next;
					bit_q <= bit_q - gcd_pkg::BIT_W'(1);
				end
			end
		end else if (cmd.rewind) begin
			idx_q <= '0;
		end else if (cmd.emit && sts.emit_adv && idx_q != LAST_SLOT) begin
			idx_q <= idx_q + SLOT_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load || resp_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			status_q  <= gcd_pkg::STATUS_OK;
			value_q   <= cur_val;
			cnt_out_q <= cur_take;
			last_q    <= !later_nz;
		end else if (resp_load) begin
			status_q  <= (rem_q == '0) ? gcd_pkg::STATUS_OK : gcd_pkg::STATUS_FAIL;
			value_q   <= '0;
			cnt_out_q <= '0;
			last_q    <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign bill_value = value_q;
	assign bill_count = cnt_out_q;
	assign last       = last_q;

	// a committed take never exceeds the supply of its slot
	a_take_le_supply: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |-> cur_take <= cur_cnt)
		else $error("take exceeds bill supply");

	// failure results carry no bills and close the transaction
	a_fail_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == gcd_pkg::STATUS_FAIL)
		|-> (last && bill_value == '0 && bill_count == '0))
		else $error("malformed failure result");

	// an empty ok result is only the single zero-amount reply
	a_empty_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bill_count == '0) |-> (last && bill_value == '0))
		else $error("empty result inside a dispense");

	// remainder only shrinks during the slot walk
	a_rem_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.div) |-> rem_q <= $past(rem_q))
		else $error("remainder grew during walk");

endmodule

@@ design/greedy_cash_dispense_unit.sv @@
// ----------------------------------------------------------------------------
// greedy_cash_dispense_unit
// Limited-supply greedy bill dispenser, sequencer plus datapath.
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready, amount): one withdrawal request per
//   transaction, taken only while no earlier request is in progress.
//   out channel (out_valid/out_ready, status, bill_value, bill_count, last):
//   one result per slot that gives bills, slot 0 first, last on the
//   final one; a refused request or a zero amount yields a single result.
//   cfg port (cfg_we, cfg_index, cfg_data): writes a slot's bill value,
//   indexes 0..4; other indexes are dropped. Write only while idle.
// sequence:
//   take the amount, then per slot a skip step (zero value, zero supply
//   or nothing left) or the bit-serial bounded quotient of up to 7 bits,
//   a check step, then the commit walk over the slots (a single reply
//   for a refused request); a zero amount goes straight to the reply.
// reset: bill values 50, 20, 10, 5, 2 and supplies 2, 2, 4, 2, 8 are loaded.
// stall: a result waits in the output register; the commit walk holds on the
//   next bill-giving slot until the receiver takes the pending result.
// ----------------------------------------------------------------------------
module greedy_cash_dispense_unit #(
	parameter int SLOTS     = 5,
	parameter int MAX_COUNT = 100
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [gcd_pkg::VAL_W-1:0]       amount,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            status,
	output logic [gcd_pkg::VAL_W-1:0]       bill_value,
	output logic [gcd_pkg::CNT_W-1:0]       bill_count,
	output logic                            last,
	input  logic                            cfg_we,
	input  logic [gcd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gcd_pkg::VAL_W-1:0]       cfg_data
);

	gcd_pkg::cmd_t cmd;
	gcd_pkg::sts_t sts;

	gcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gcd_dp #(
		.SLOTS     (SLOTS),
		.MAX_COUNT (MAX_COUNT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.amount     (amount),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.bill_value (bill_value),
		.bill_count (bill_count),
		.last       (last)
	);

endmodule

@@ dv/tb_greedy_cash_dispense_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_cash_dispense_unit
// Drives withdrawal requests into the dispense unit under several bill value
// settings and checks every result against a greedy limited-supply predictor.
// ----------------------------------------------------------------------------
module tb_greedy_cash_dispense_unit;

	localparam int NUM_DENOM = 5;
	localparam int HOLD_CYCLES = 200;

	localparam logic [gcd_pkg::CFG_IDX_W-1:0] REG_DENOM_FIRST  = gcd_pkg::CFG_IDX_W'(0);
	localparam logic [gcd_pkg::CFG_IDX_W-1:0] REG_DENOM_SECOND = gcd_pkg::CFG_IDX_W'(1);
	localparam logic [gcd_pkg::CFG_IDX_W-1:0] REG_DENOM_THIRD  = gcd_pkg::CFG_IDX_W'(2);
	localparam logic [gcd_pkg::CFG_IDX_W-1:0] REG_DENOM_FOURTH = gcd_pkg::CFG_IDX_W'(3);
	localparam logic [gcd_pkg::CFG_IDX_W-1:0] REG_DENOM_FIFTH  = gcd_pkg::CFG_IDX_W'(4);

	typedef struct packed {
		logic                      status;
		logic [gcd_pkg::VAL_W-1:0] value;
		logic [gcd_pkg::CNT_W-1:0] count;
		logic                      last;
	} payout_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [gcd_pkg::VAL_W-1:0]     amount = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          status;
	logic [gcd_pkg::VAL_W-1:0]     bill_value;
	logic [gcd_pkg::CNT_W-1:0]     bill_count;
	logic                          last;
	logic                          cfg_we = 1'b0;
	logic [gcd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [gcd_pkg::VAL_W-1:0]     cfg_data = '0;

	// predictor state: bill values and remaining supply per slot
	logic [gcd_pkg::VAL_W-1:0] bill_val [NUM_DENOM] = '{16'd50, 16'd20, 16'd10, 16'd5, 16'd2};
	logic [gcd_pkg::CNT_W-1:0] bill_stock [NUM_DENOM] = '{7'd2, 7'd2, 7'd4, 7'd2, 7'd8};

	logic [gcd_pkg::VAL_W-1:0] amount_q [$];
	payout_t                   payout_q [$];

	int   errors = 0;
	logic in_took = 1'b0;
	logic quiet = 1'b0;
	logic hold_req = 1'b0;
	logic hold_seen = 1'b0;
	int   tx_gap = 0;
	int   rx_stall = 0;
	int   hold_left = 0;

	greedy_cash_dispense_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.amount     (amount),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.bill_value (bill_value),
		.bill_count (bill_count),
		.last       (last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_greedy_cash_dispense_unit NOT OK");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic predict_dispense(input logic [gcd_pkg::VAL_W-1:0] amt);
		payout_t                   p;
		int                        left;
		int                        q;
		logic [gcd_pkg::CNT_W-1:0] take [NUM_DENOM];
		left = amt;
		if (amt == 0) begin
			p = '{gcd_pkg::STATUS_OK, '0, '0, 1'b1};
			payout_q.push_back(p);
			return;
		end
		for (int s = 0; s < NUM_DENOM; s++) begin
			take[s] = '0;
			if (left != 0 && bill_val[s] != 0) begin
				q = left / int'(bill_val[s]);
				if (q > int'(bill_stock[s])) q = bill_stock[s];
				take[s] = gcd_pkg::CNT_W'(q);
				left -= q * int'(bill_val[s]);
			end
		end
		if (left != 0) begin
			p = '{gcd_pkg::STATUS_FAIL, '0, '0, 1'b1};
			payout_q.push_back(p);
			return;
		end
		for (int s = 0; s < NUM_DENOM; s++) begin
			if (take[s] != 0) begin
				bill_stock[s] = bill_stock[s] - take[s];
				p = '{gcd_pkg::STATUS_OK, bill_val[s], take[s], 1'b0};
				payout_q.push_back(p);
			end
		end
		payout_q[payout_q.size() - 1].last = 1'b1;
	endtask

	task automatic write_denom(input logic [gcd_pkg::CFG_IDX_W-1:0] idx,
			input logic [gcd_pkg::VAL_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx < NUM_DENOM) bill_val[idx] = data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (amount_q.size() != 0 || in_valid || payout_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic logic [gcd_pkg::VAL_W-1:0] rand_denom();
		int r;
		r = $urandom_range(0, 7);
		if (r < 2) return gcd_pkg::VAL_W'($urandom_range(1, 8));
		if (r < 4) return gcd_pkg::VAL_W'($urandom_range(1, 100));
		if (r < 6) return gcd_pkg::VAL_W'($urandom_range(1, 65535));
		if (r == 6) return 16'hFFFF;
		return 16'd1;
	endfunction

	// mostly sums of configured bills, the rest zero or arbitrary
	function automatic logic [gcd_pkg::VAL_W-1:0] pick_amount();
		int r;
		int sum;
		r = $urandom_range(0, 99);
		if (r < 8) return '0;
		if (r < 25) return gcd_pkg::VAL_W'($urandom());
		sum = 0;
		for (int s = 0; s < NUM_DENOM; s++) begin
			if ($urandom_range(0, 1)) sum += int'(bill_val[s]) * $urandom_range(1, 2);
		end
		if (sum == 0) sum = bill_val[NUM_DENOM - 1];
		return gcd_pkg::VAL_W'(sum);
	endfunction

	// sender: next request loaded after the previous transaction and its gap
	always @(negedge clk) begin : drive_requests
		logic                      nxt_valid;
		logic [gcd_pkg::VAL_W-1:0] nxt_amount;
		if (arst_n) begin
			nxt_valid = in_valid;
			nxt_amount = amount;
			if (!in_valid || in_took) begin
				nxt_valid = 1'b0;
				if (in_valid) tx_gap = idle_len();
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (amount_q.size() != 0) begin
					nxt_valid = 1'b1;
					nxt_amount = amount_q.pop_front();
				end
			end
			in_valid <= nxt_valid;
			amount <= nxt_amount;
		end
	end

	// receiver: random stalls plus an occasional long hold-off
	always @(negedge clk) begin : drive_ready
		if (arst_n) begin
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) rx_stall = idle_len();
			end
		end
	end

	always @(posedge clk) begin : watch_results
		payout_t want;
		in_took = arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (payout_q.size() == 0) begin
				report_mismatch("unexpected result, status", status, 0);
			end else begin
				want = payout_q.pop_front();
				if (status !== want.status) report_mismatch("status", status, want.status);
				if (bill_value !== want.value) report_mismatch("bill_value", bill_value, want.value);
				if (bill_count !== want.count) report_mismatch("bill_count", bill_count, want.count);
				if (last !== want.last) report_mismatch("last", last, want.last);
			end
		end
		if (in_took) predict_dispense(amount);
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset bill values, no idling at first
		quiet = 1'b1;
		amount_q = '{16'd0, 16'd1, 16'hFFFF, 16'd3, 16'd50, 16'd87, 16'd7, 16'd4};
		wait_drained();
		quiet = 1'b0;

		// duplicate top values, zero slot, misordered smallest slot, stray indexes
		write_denom(REG_DENOM_FIRST, 16'hFFFF);
		write_denom(REG_DENOM_SECOND, 16'hFFFF);
		write_denom(REG_DENOM_THIRD, 16'd1);
		write_denom(REG_DENOM_FOURTH, 16'd0);
		write_denom(REG_DENOM_FIFTH, 16'h8000);
		write_denom(gcd_pkg::CFG_IDX_W'(NUM_DENOM), 16'h5555);
		write_denom(gcd_pkg::CFG_IDX_W'(NUM_DENOM + 1), 16'hAAAA);
		write_denom(gcd_pkg::CFG_IDX_W'(NUM_DENOM + 2), 16'hFFFF);
		amount_q = '{16'hFFFF, 16'h8001, 16'h8000, 16'd2, 16'd0, 16'd1};
		wait_drained();

		write_denom(REG_DENOM_FOURTH, 16'd1);
		write_denom(REG_DENOM_FIFTH, 16'd1);
		amount_q = '{16'd1, 16'd2, 16'd5, 16'hFFFF};
		wait_drained();

		for (int ph = 0; ph < 5; ph++) begin
			write_denom(REG_DENOM_FIRST, rand_denom());
			write_denom(REG_DENOM_SECOND, rand_denom());
			write_denom(REG_DENOM_THIRD, rand_denom());
			write_denom(REG_DENOM_FOURTH, rand_denom());
			write_denom(REG_DENOM_FIFTH, rand_denom());
			if (ph == 0) hold_req = ~hold_req;
			quiet = (ph == 2);
			for (int i = 0; i < 20; i++) amount_q.push_back(pick_amount());
			wait_drained();
		end
		quiet = 1'b0;

		if (payout_q.size() != 0) report_mismatch("results never seen", payout_q.size(), 0);
		if (errors == 0) begin
			$display("tb_greedy_cash_dispense_unit OK");
		end else begin
			$display("tb_greedy_cash_dispense_unit NOT OK");
		end
		$finish;
	end

endmodule

@@ greedy_cash_dispense_unit.f @@
design/gcd_pkg.sv
design/gcd_ctrl.sv
design/gcd_dp.sv
design/greedy_cash_dispense_unit.sv
dv/tb_greedy_cash_dispense_unit.sv
